@@ rtl/uart_8n1_transceiver_fifo_top_assert.svh @@
// ---------------------------------------------------------------------------
// uart_8n1_transceiver_fifo_top_assert.svh
// Shared assertion macros for the UART transceiver RTL.
// ---------------------------------------------------------------------------
`ifndef UART_8N1_TRANSCEIVER_FIFO_TOP_ASSERT_SVH
`define UART_8N1_TRANSCEIVER_FIFO_TOP_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define UARTF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("uartf: same-cycle check failed");

// Next-cycle implication, masked during reset.
`define UARTF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("uartf: next-cycle check failed");

`endif

@@ rtl/uartf_pkg.sv @@
// ---------------------------------------------------------------------------
// uartf_pkg
// Types and constants shared by the UART transceiver modules.
// ---------------------------------------------------------------------------
`default_nettype none

package uartf_pkg;

   // Receive ring
   localparam int DEPTH = 64;
   localparam int PTR_W = $clog2(DEPTH);
   localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
   localparam int CNT_W = ((PTR_W + 1) > 7) ? (PTR_W + 1) : 7;
   localparam int WAIT_W = 6;
   localparam logic [WAIT_W-1:0] WAIT_MAX = 6'd63;

   // Request codes
   localparam logic [1:0] ACT_TICK = 2'd0;
   localparam logic [1:0] ACT_POP  = 2'd1;
   localparam logic [1:0] ACT_SEND = 2'd2;

   // Register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_BIT_TICKS    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_DELAY = 1'd1;

   // Receiver phases
   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_DELAY = 2'd1;
   localparam logic [1:0] PH_DATA  = 2'd2;
   localparam logic [1:0] PH_STOP  = 2'd3;

   // Frame shape
   localparam logic [3:0] DATA_BITS  = 4'd8;
   localparam logic [3:0] FRAME_BITS = 4'd10;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } push_type;

   typedef struct packed {
      logic              read_valid;
      logic              use_bypass;
      logic [7:0]        bypass_data;
      logic [WAIT_W-1:0] bytes_waiting;
      logic              overflow_drop;
   } pop_type;

   typedef struct packed {
      logic    tx_level;
      pop_type pop;
      logic    send_accepted;
      logic    tx_busy;
      logic    rx_busy;
   } stage_type;

   typedef struct packed {
      logic              tx_level;
      logic [7:0]        read_data;
      logic              read_valid;
      logic [WAIT_W-1:0] bytes_waiting;
      logic              overflow_drop;
      logic              send_accepted;
      logic              tx_busy;
      logic              rx_busy;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/uartf_ram.sv @@
// ---------------------------------------------------------------------------
// uartf_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module uartf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/uartf_rx.sv @@
// ---------------------------------------------------------------------------
// uartf_rx
// 8N1 receiver: start edge detect, bit timing, LSB-first sampling.
// ---------------------------------------------------------------------------
`default_nettype none
`include "uart_8n1_transceiver_fifo_top_assert.svh"

module uartf_rx (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic              rx_level,
   input  wire logic [15:0]       bit_ticks,
   input  wire logic [15:0]       sample_delay,
   output uartf_pkg::push_type    push,
   output logic                   rx_busy
);

   logic        line_prev_ff, line_prev_in;
   logic [1:0]  phase_ff, phase_in;
   logic [15:0] timer_ff, timer_in;
   logic [3:0]  count_ff, count_in;
   logic [7:0]  shift_ff, shift_in;
   logic [15:0] timer_dec;
   logic [3:0]  count_inc;

   assign timer_dec = timer_ff - 16'd1;
   assign count_inc = count_ff + 4'd1;

   always_comb begin
      phase_in     = phase_ff;
      timer_in     = timer_ff;
      count_in     = count_ff;
      shift_in     = shift_ff;
      line_prev_in = rx_level;
      push         = '0;
      if (phase_ff == uartf_pkg::PH_IDLE) begin
         if ((bit_ticks != 16'd0) && line_prev_ff && !rx_level) begin
            count_in = 4'd0;
            shift_in = 8'd0;
            if (sample_delay == 16'd0) begin
               phase_in = uartf_pkg::PH_DATA;
               timer_in = bit_ticks;
            end else begin
               phase_in = uartf_pkg::PH_DELAY;
               timer_in = sample_delay;
            end
         end
      end else if ((bit_ticks == 16'd0) || (timer_ff == 16'd0)) begin
         // disabled mid-frame or timer already zero: drop the partial byte
         phase_in = uartf_pkg::PH_IDLE;
         timer_in = 16'd0;
         count_in = 4'd0;
         shift_in = 8'd0;
      end else begin
         timer_in = timer_dec;
         if (timer_dec == 16'd0) begin
            case (phase_ff)
               uartf_pkg::PH_DELAY: begin
                  phase_in = uartf_pkg::PH_DATA;
                  timer_in = bit_ticks;
               end
               uartf_pkg::PH_DATA: begin
                  if (rx_level) begin
                     shift_in[count_ff[2:0]] = 1'b1;
                  end
                  count_in = count_inc;
                  if (count_inc >= uartf_pkg::DATA_BITS) begin
                     phase_in = uartf_pkg::PH_STOP;
                  end
                  timer_in = bit_ticks;
               end
               default: begin
                  // end of stop bit, level not checked
                  push.valid = 1'b1;
                  push.data  = shift_ff;
                  phase_in   = uartf_pkg::PH_IDLE;
                  count_in   = 4'd0;
                  shift_in   = 8'd0;
               end
            endcase
         end
      end
   end

   assign rx_busy = (phase_in != uartf_pkg::PH_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         line_prev_ff <= 1'b1;
         phase_ff     <= uartf_pkg::PH_IDLE;
         timer_ff     <= 16'd0;
         count_ff     <= 4'd0;
         shift_ff     <= 8'd0;
      end else if (step) begin
         line_prev_ff <= line_prev_in;
         phase_ff     <= phase_in;
         timer_ff     <= timer_in;
         count_ff     <= count_in;
         shift_ff     <= shift_in;
      end
   end

   `UARTF_ASSERT_NOW(a_rx_idle_clear, clock, reset,
      phase_ff == uartf_pkg::PH_IDLE, (count_ff == 4'd0) && (shift_ff == 8'd0))

endmodule

`default_nettype wire

@@ rtl/uartf_tx.sv @@
// ---------------------------------------------------------------------------
// uartf_tx
// 8N1 transmitter: start bit, 8 data bits LSB first, stop bit.
// ---------------------------------------------------------------------------
`default_nettype none
`include "uart_8n1_transceiver_fifo_top_assert.svh"

module uartf_tx (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step,
   input  wire logic        send,
   input  wire logic [7:0]  tx_byte,
   input  wire logic [15:0] bit_ticks,
   output logic             tx_level,
   output logic             tx_busy,
   output logic             send_accepted
);

   logic        active_ff, active_in;
   logic [15:0] timer_ff, timer_in;
   logic [3:0]  count_ff, count_in;
   logic [7:0]  shift_ff, shift_in;
   logic        line_ff, line_in;
   logic [3:0]  bit_sel;

   always_comb begin
      active_in     = active_ff;
      timer_in      = timer_ff;
      count_in      = count_ff;
      shift_in      = shift_ff;
      line_in       = line_ff;
      send_accepted = 1'b0;
      bit_sel       = 4'd0;

      // abandon frame when disabled or timer ran out
      if (active_in && ((bit_ticks == 16'd0) || (timer_in == 16'd0))) begin
         active_in = 1'b0;
         timer_in  = 16'd0;
         count_in  = 4'd0;
         line_in   = 1'b1;
      end
      if (send && !active_in && (bit_ticks != 16'd0)) begin
         active_in     = 1'b1;
         count_in      = 4'd0;
         timer_in      = bit_ticks;
         shift_in      = tx_byte;
         line_in       = 1'b0;
         send_accepted = 1'b1;
      end

      tx_level = line_in;
      tx_busy  = active_in;

      if (active_in) begin
         timer_in = timer_in - 16'd1;
         if (timer_in == 16'd0) begin
            count_in = count_in + 4'd1;
            bit_sel  = count_in - 4'd1;
            if (count_in >= uartf_pkg::FRAME_BITS) begin
               active_in = 1'b0;
               timer_in  = 16'd0;
               count_in  = 4'd0;
               line_in   = 1'b1;
            end else begin
               if (count_in <= uartf_pkg::DATA_BITS) begin
                  line_in = shift_in[bit_sel[2:0]];
               end else begin
                  line_in = 1'b1;
               end
               timer_in = bit_ticks;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         timer_ff  <= 16'd0;
         count_ff  <= 4'd0;
         shift_ff  <= 8'd0;
         line_ff   <= 1'b1;
      end else if (step) begin
         active_ff <= active_in;
         timer_ff  <= timer_in;
         count_ff  <= count_in;
         shift_ff  <= shift_in;
         line_ff   <= line_in;
      end
   end

   `UARTF_ASSERT_NOW(a_tx_idle_high, clock, reset, !active_ff, line_ff)
   `UARTF_ASSERT_NOW(a_tx_count_range, clock, reset,
      active_ff, count_ff < uartf_pkg::FRAME_BITS)

endmodule

`default_nettype wire

@@ rtl/uartf_ring.sv @@
// ---------------------------------------------------------------------------
// uartf_ring
// Receive ring buffer: pointers, full/empty, fill count, RAM access.
// ---------------------------------------------------------------------------
`default_nettype none
`include "uart_8n1_transceiver_fifo_top_assert.svh"

module uartf_ring (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire uartf_pkg::push_type push,
   input  wire logic               pop_req,
   output uartf_pkg::pop_type      status,
   output logic [7:0]              rd_data
);

   logic [uartf_pkg::PTR_W-1:0] wp_ff, wp_in, rp_ff, rp_in, wp_inc, rp_inc;
   logic [uartf_pkg::CNT_W-1:0] wp_ext, rp_ext, fill;
   logic full, do_push, do_pop;

   assign wp_inc = (wp_ff == uartf_pkg::PTR_MAX) ? '0 : wp_ff + uartf_pkg::PTR_W'(1);
   assign rp_inc = (rp_ff == uartf_pkg::PTR_MAX) ? '0 : rp_ff + uartf_pkg::PTR_W'(1);

   assign full    = (wp_inc == rp_ff);
   assign do_push = push.valid && !full;
   assign wp_in   = do_push ? wp_inc : wp_ff;
   // pop sees the byte pushed in the same tick
   assign do_pop  = pop_req && (wp_in != rp_ff);
   assign rp_in   = do_pop ? rp_inc : rp_ff;

   assign wp_ext = uartf_pkg::CNT_W'(wp_in);
   assign rp_ext = uartf_pkg::CNT_W'(rp_in);
   assign fill   = (wp_ext >= rp_ext) ? (wp_ext - rp_ext)
                 : (uartf_pkg::CNT_W'(uartf_pkg::DEPTH) + wp_ext - rp_ext);

   always_comb begin
      status.read_valid    = do_pop;
      // empty ring: a pushed byte popped in the same tick is forwarded around the RAM
      status.use_bypass    = do_push && (rp_ff == wp_ff);
      status.bypass_data   = push.data;
      status.overflow_drop = push.valid && full;
      if (fill > uartf_pkg::CNT_W'(uartf_pkg::WAIT_MAX)) begin
         status.bytes_waiting = uartf_pkg::WAIT_MAX;
      end else begin
         status.bytes_waiting = fill[uartf_pkg::WAIT_W-1:0];
      end
   end

   uartf_ram #(
      .WIDTH (8),
      .DEPTH (uartf_pkg::DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (step && do_push),
      .wr_addr (wp_ff),
      .wr_data (push.data),
      .rd_en   (step && do_pop),
      .rd_addr (rp_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
      end else if (step) begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
      end
   end

   `UARTF_ASSERT_NOW(a_ring_ptr_range, clock, reset, 1'b1,
      (wp_ff <= uartf_pkg::PTR_MAX) && (rp_ff <= uartf_pkg::PTR_MAX))

endmodule

`default_nettype wire

@@ rtl/uart_8n1_transceiver_fifo_top.sv @@
// ---------------------------------------------------------------------------
// uart_8n1_transceiver_fifo_top
// UART 8N1 transceiver with receive ring buffer, one line tick per item.
// ---------------------------------------------------------------------------
// Usage:
//  - req_* : one item per line tick: rx line level, and action
//    (tick only, pop a received byte, or send req_tx_byte).
//  - rsp_* : one result item per request item, in order: tx line level,
//    popped byte, fill count, drop/accept flags and busy flags.
//  - csr_* : register 0 is bit_ticks, 1 is sample_delay. Always ready;
//    write only while no item is in flight.
// Throughput: one item per cycle while rsp_ready is high. Each result is
//  registered in stage 1 (state update and ring RAM read), then in the
//  result register.
// The registered RAM read sets the extra stage; a byte pushed and popped in
//  the same tick is forwarded around the RAM.
// Reset: synchronous; line state idle high, ring empty, both registers 0
//  (transmit and receive disabled). The ring needs no clearing pass.
// Stall: when rsp_ready is low the result register holds and the middle
//  stage can still fill, so req_ready drops only when both are full.
// ---------------------------------------------------------------------------
`default_nettype none
`include "uart_8n1_transceiver_fifo_top_assert.svh"

module uart_8n1_transceiver_fifo_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [1:0]                      req_action,
   input  wire logic                            req_rx_level,
   input  wire logic [7:0]                      req_tx_byte,
   // result channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_tx_level,
   output logic [7:0]                           rsp_read_data,
   output logic                                 rsp_read_valid,
   output logic [uartf_pkg::WAIT_W-1:0]         rsp_bytes_waiting,
   output logic                                 rsp_overflow_drop,
   output logic                                 rsp_send_accepted,
   output logic                                 rsp_tx_busy,
   output logic                                 rsp_rx_busy,
   // register write channel
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [uartf_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [15:0]                     csr_data
);

   logic [15:0] bit_ticks_ff, sample_delay_ff;

   logic step;
   logic s1_move;
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   uartf_pkg::stage_type  s1_ff, s1_in;
   uartf_pkg::result_type rsp_ff, rsp_in;

   uartf_pkg::push_type push;
   uartf_pkg::pop_type  pop_status;
   logic [7:0] ram_data;
   logic tx_level, tx_busy, send_accepted, rx_busy;

   // ---- registers ----
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ticks_ff    <= 16'd0;
         sample_delay_ff <= 16'd0;
      end else if (csr_valid) begin
         case (csr_index)
            uartf_pkg::CSR_BIT_TICKS:    bit_ticks_ff    <= csr_data;
            uartf_pkg::CSR_SAMPLE_DELAY: sample_delay_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // ---- handshake: stage 1 advances whenever the result register frees ----
   assign s1_move   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || s1_move;
   assign step      = req_valid && req_ready;

   // ---- per-tick datapath, state updates on accept ----
   uartf_rx u_rx (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .rx_level     (req_rx_level),
      .bit_ticks    (bit_ticks_ff),
      .sample_delay (sample_delay_ff),
      .push         (push),
      .rx_busy      (rx_busy)
   );

   uartf_ring u_ring (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .push    (push),
      .pop_req (req_action == uartf_pkg::ACT_POP),
      .status  (pop_status),
      .rd_data (ram_data)
   );

   uartf_tx u_tx (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .send          (req_action == uartf_pkg::ACT_SEND),
      .tx_byte       (req_tx_byte),
      .bit_ticks     (bit_ticks_ff),
      .tx_level      (tx_level),
      .tx_busy       (tx_busy),
      .send_accepted (send_accepted)
   );

   always_comb begin
      s1_in.tx_level      = tx_level;
      s1_in.pop           = pop_status;
      s1_in.send_accepted = send_accepted;
      s1_in.tx_busy       = tx_busy;
      s1_in.rx_busy       = rx_busy;
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (step) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   // ---- result assembly: RAM read data lands during stage 1 ----
   always_comb begin
      rsp_in.tx_level      = s1_ff.tx_level;
      rsp_in.read_valid    = s1_ff.pop.read_valid;
      rsp_in.bytes_waiting = s1_ff.pop.bytes_waiting;
      rsp_in.overflow_drop = s1_ff.pop.overflow_drop;
      rsp_in.send_accepted = s1_ff.send_accepted;
      rsp_in.tx_busy       = s1_ff.tx_busy;
      rsp_in.rx_busy       = s1_ff.rx_busy;
      if (!s1_ff.pop.read_valid) begin
         rsp_in.read_data = 8'd0;
      end else if (s1_ff.pop.use_bypass) begin
         rsp_in.read_data = s1_ff.pop.bypass_data;
      end else begin
         rsp_in.read_data = ram_data;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_valid_ff && s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         s1_ff <= s1_in;
      end
      if (s1_valid_ff && s1_move) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tx_level      = rsp_ff.tx_level;
   assign rsp_read_data     = rsp_ff.read_data;
   assign rsp_read_valid    = rsp_ff.read_valid;
   assign rsp_bytes_waiting = rsp_ff.bytes_waiting;
   assign rsp_overflow_drop = rsp_ff.overflow_drop;
   assign rsp_send_accepted = rsp_ff.send_accepted;
   assign rsp_tx_busy       = rsp_ff.tx_busy;
   assign rsp_rx_busy       = rsp_ff.rx_busy;

   `UARTF_ASSERT_NEXT(a_accept_fills_stage, clock, reset, step, s1_valid_ff)
   `UARTF_ASSERT_NOW(a_stall_means_full, clock, reset, !req_ready,
      s1_valid_ff && rsp_valid_ff)

endmodule

`default_nettype wire
